/* rtl/sfl_pkg.sv */
// shared types and codes for the frequency-sorted symbol list
package sfl_pkg;

  typedef enum logic [1:0] {
    OP_COUNT  = 2'd0,
    OP_READ   = 2'd1,
    OP_REMOVE = 2'd2
  } op_t;

  typedef enum logic [1:0] {
    STAT_COUNTED = 2'd0,
    STAT_ADDED   = 2'd1,
    STAT_DONE    = 2'd2,
    STAT_REFUSED = 2'd3
  } status_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_SEARCH,
    S_SCAN,
    S_SWAP_A,
    S_SWAP_B,
    S_SHIFT_UP,
    S_FETCH,
    S_GRAB,
    S_SHIFT_DN,
    S_RESULT
  } seq_state_t;

endpackage

/* rtl/sorted_symbol_frequency_list_core.sv */
// frequency-sorted symbol list: entry memory, sequencer and result register
//
// one request in, one result out per request, valid/stall handshake on both channels
// in_operation: count symbol, read at rank, remove at rank
// entries live in one memory with a single read and a single write port; every
// walk over the list moves one entry per cycle through that read port
// steps per request, in order:
//   count, known symbol:  search, scan of the lower-count run after the hit,
//                         swap in S_SWAP_A (and S_SWAP_B if it moves), result
//   count, new symbol:    search, shift up, result
//   count, list full:     search, result
//   read:                 fetch, grab, result
//   remove at rank p:     fetch, grab, shift down, result
//   refused read, remove or undefined operation: result
// requests do not overlap: the next is taken only once the sequencer is idle again
// in_stall is low only while the sequencer is idle; a finished result waits in the
// output register while the next request is taken, and the sequencer holds in its
// result state while out_stall keeps that register full
// reset empties the list at once (no clearing pass); memory contents are left as is
module sorted_symbol_frequency_list_core #(
  parameter int MAX_SYMBOLS = 256,
  parameter int COUNT_WIDTH = 32
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  in_operation,
  input  logic [7:0]  in_symbol,
  input  logic [7:0]  in_position,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  out_status,
  output logic [7:0]  out_symbol,
  output logic [31:0] out_frequency,
  output logic [8:0]  out_entry_count
);
  import sfl_pkg::*;

  localparam int AW = $clog2(MAX_SYMBOLS);
  localparam int LW = $clog2(MAX_SYMBOLS + 1);
  localparam int CW = COUNT_WIDTH;
  localparam logic [LW-1:0] LEN_FULL = LW'(MAX_SYMBOLS);

  // entry memory
  logic [7:0]    sym_mem [MAX_SYMBOLS];
  logic [CW-1:0] cnt_mem [MAX_SYMBOLS];
  logic          mem_we;
  logic [AW-1:0] mem_wa;
  logic [7:0]    mem_wsym;
  logic [CW-1:0] mem_wcnt;
  logic [AW-1:0] mem_ra;
  logic [7:0]    sym_q_r;
  logic [CW-1:0] cnt_q_r;

  seq_state_t state_r, state_nxt;
  logic [LW-1:0] len_r, len_nxt;
  logic          pend_r, pend_nxt;
  logic [AW-1:0] src_r, src_nxt;
  logic [LW-1:0] ptr_r, ptr_nxt;
  logic [AW-1:0] hit_r, hit_nxt;
  logic [AW-1:0] jdx_r, jdx_nxt;
  logic [7:0]    jsym_r, jsym_nxt;
  logic [CW-1:0] jcnt_r, jcnt_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic [7:0]    osym_r, osym_nxt;
  status_t       st_r, st_nxt;
  op_t           op_r, op_nxt;
  logic [7:0]    sym_r, sym_nxt;
  logic [7:0]    pos_r, pos_nxt;

  logic          out_valid_r, out_valid_nxt;
  logic [1:0]    out_status_r, out_status_nxt;
  logic [7:0]    out_symbol_r, out_symbol_nxt;
  logic [31:0]   out_freq_r, out_freq_nxt;
  logic [8:0]    out_count_r, out_count_nxt;

  logic          in_take;
  logic          in_range;
  logic          search_hit;
  logic          scan_lower;
  logic          can_issue;
  logic          scan_go;
  logic          out_free;
  logic [LW-1:0] ptr_dec;
  logic [CW-1:0] cnt_inc;
  logic [63:0]   cnt_ext;

  assign in_take    = in_valid && (state_r == S_IDLE);
  assign in_range   = {1'b0, in_position} < 9'(len_r);
  assign search_hit = pend_r && (sym_q_r == sym_r);
  assign scan_lower = pend_r && (cnt_r > cnt_q_r);
  assign can_issue  = ptr_r < len_r;
  assign scan_go    = !(pend_r && !scan_lower) && can_issue;
  assign out_free   = !out_valid_r || !out_stall;
  assign ptr_dec    = LW'(ptr_r - 1'b1);
  assign cnt_inc    = (cnt_q_r == {CW{1'b1}}) ? cnt_q_r : CW'(cnt_q_r + 1'b1);
  assign cnt_ext    = 64'(cnt_r);

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          unique case (in_operation) inside
            OP_COUNT:             state_nxt = S_SEARCH;
            OP_READ, OP_REMOVE:   state_nxt = in_range ? S_FETCH : S_RESULT;
            default:              state_nxt = S_RESULT;
          endcase
        end
      end
      S_SEARCH: begin
        if (search_hit) begin
          state_nxt = S_SCAN;
        end else if (!can_issue) begin
          state_nxt = (len_r == LEN_FULL) ? S_RESULT : S_SHIFT_UP;
        end
      end
      S_SCAN: begin
        if (!scan_go) state_nxt = S_SWAP_A;
      end
      S_SWAP_A: state_nxt = (jdx_r == hit_r) ? S_RESULT : S_SWAP_B;
      S_SWAP_B: state_nxt = S_RESULT;
      S_SHIFT_UP: begin
        if ((ptr_r == '0) && !pend_r) state_nxt = S_RESULT;
      end
      S_FETCH: state_nxt = S_GRAB;
      S_GRAB:  state_nxt = (op_r == OP_REMOVE) ? S_SHIFT_DN : S_RESULT;
      S_SHIFT_DN: begin
        if (!can_issue && !pend_r) state_nxt = S_RESULT;
      end
      S_RESULT: begin
        if (out_free) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // datapath and memory control
  always_comb begin
    len_nxt        = len_r;
    pend_nxt       = pend_r;
    src_nxt        = src_r;
    ptr_nxt        = ptr_r;
    hit_nxt        = hit_r;
    jdx_nxt        = jdx_r;
    jsym_nxt       = jsym_r;
    jcnt_nxt       = jcnt_r;
    cnt_nxt        = cnt_r;
    osym_nxt       = osym_r;
    st_nxt         = st_r;
    op_nxt         = op_r;
    sym_nxt        = sym_r;
    pos_nxt        = pos_r;
    out_valid_nxt  = out_valid_r && out_stall;
    out_status_nxt = out_status_r;
    out_symbol_nxt = out_symbol_r;
    out_freq_nxt   = out_freq_r;
    out_count_nxt  = out_count_r;
    mem_we         = 1'b0;
    mem_wa         = hit_r;
    mem_wsym       = sym_r;
    mem_wcnt       = cnt_r;
    mem_ra         = ptr_r[AW-1:0];

    unique case (state_r)
      S_IDLE: begin
        pend_nxt = 1'b0;
        ptr_nxt  = '0;
        if (in_valid) begin
          op_nxt   = op_t'(in_operation);
          sym_nxt  = in_symbol;
          pos_nxt  = in_position;
          st_nxt   = STAT_REFUSED;
          osym_nxt = '0;
          cnt_nxt  = '0;
        end
      end
      S_SEARCH: begin
        if (search_hit) begin
          hit_nxt  = src_r;
          jdx_nxt  = src_r;
          cnt_nxt  = cnt_inc;
          ptr_nxt  = LW'(LW'(src_r) + 1'b1);
          pend_nxt = 1'b0;
        end else if (can_issue) begin
          mem_ra   = ptr_r[AW-1:0];
          src_nxt  = ptr_r[AW-1:0];
          ptr_nxt  = LW'(ptr_r + 1'b1);
          pend_nxt = 1'b1;
        end else begin
          pend_nxt = 1'b0;
          ptr_nxt  = len_r;
          st_nxt   = STAT_REFUSED;
          osym_nxt = sym_r;
          cnt_nxt  = '0;
        end
      end
      S_SCAN: begin
        if (scan_lower) begin
          jdx_nxt  = src_r;
          jsym_nxt = sym_q_r;
          jcnt_nxt = cnt_q_r;
        end
        if (scan_go) begin
          mem_ra   = ptr_r[AW-1:0];
          src_nxt  = ptr_r[AW-1:0];
          ptr_nxt  = LW'(ptr_r + 1'b1);
          pend_nxt = 1'b1;
        end else begin
          pend_nxt = 1'b0;
        end
      end
      S_SWAP_A: begin
        mem_we   = 1'b1;
        mem_wa   = hit_r;
        st_nxt   = STAT_COUNTED;
        osym_nxt = sym_r;
        if (jdx_r == hit_r) begin
          mem_wsym = sym_r;
          mem_wcnt = cnt_r;
        end else begin
          mem_wsym = jsym_r;
          mem_wcnt = jcnt_r;
        end
      end
      S_SWAP_B: begin
        mem_we   = 1'b1;
        mem_wa   = jdx_r;
        mem_wsym = sym_r;
        mem_wcnt = cnt_r;
      end
      S_SHIFT_UP: begin
        if (pend_r) begin
          mem_we   = 1'b1;
          mem_wa   = AW'(src_r + 1'b1);
          mem_wsym = sym_q_r;
          mem_wcnt = cnt_q_r;
        end
        if (ptr_r != '0) begin
          mem_ra   = ptr_dec[AW-1:0];
          src_nxt  = ptr_dec[AW-1:0];
          ptr_nxt  = ptr_dec;
          pend_nxt = 1'b1;
        end else if (pend_r) begin
          pend_nxt = 1'b0;
        end else begin
          mem_we   = 1'b1;
          mem_wa   = '0;
          mem_wsym = sym_r;
          mem_wcnt = CW'(1);
          len_nxt  = LW'(len_r + 1'b1);
          cnt_nxt  = CW'(1);
          st_nxt   = STAT_ADDED;
          osym_nxt = sym_r;
        end
      end
      S_FETCH: begin
        mem_ra = pos_r[AW-1:0];
      end
      S_GRAB: begin
        osym_nxt = sym_q_r;
        cnt_nxt  = cnt_q_r;
        st_nxt   = STAT_DONE;
        ptr_nxt  = LW'(LW'(pos_r[AW-1:0]) + 1'b1);
        pend_nxt = 1'b0;
      end
      S_SHIFT_DN: begin
        if (pend_r) begin
          mem_we   = 1'b1;
          mem_wa   = AW'(src_r - 1'b1);
          mem_wsym = sym_q_r;
          mem_wcnt = cnt_q_r;
        end
        if (can_issue) begin
          mem_ra   = ptr_r[AW-1:0];
          src_nxt  = ptr_r[AW-1:0];
          ptr_nxt  = LW'(ptr_r + 1'b1);
          pend_nxt = 1'b1;
        end else if (pend_r) begin
          pend_nxt = 1'b0;
        end else begin
          len_nxt = LW'(len_r - 1'b1);
        end
      end
      S_RESULT: begin
        if (out_free) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = st_r;
          out_symbol_nxt = osym_r;
          out_freq_nxt   = cnt_ext[31:0];
          out_count_nxt  = 9'(len_r);
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      sym_mem[mem_wa] <= mem_wsym;
      cnt_mem[mem_wa] <= mem_wcnt;
    end
  end

  always_ff @(posedge clk) begin
    sym_q_r <= sym_mem[mem_ra];
    cnt_q_r <= cnt_mem[mem_ra];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      len_r       <= '0;
      pend_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      len_r       <= len_nxt;
      pend_r      <= pend_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    src_r        <= src_nxt;
    ptr_r        <= ptr_nxt;
    hit_r        <= hit_nxt;
    jdx_r        <= jdx_nxt;
    jsym_r       <= jsym_nxt;
    jcnt_r       <= jcnt_nxt;
    cnt_r        <= cnt_nxt;
    osym_r       <= osym_nxt;
    st_r         <= st_nxt;
    op_r         <= op_nxt;
    sym_r        <= sym_nxt;
    pos_r        <= pos_nxt;
    out_status_r <= out_status_nxt;
    out_symbol_r <= out_symbol_nxt;
    out_freq_r   <= out_freq_nxt;
    out_count_r  <= out_count_nxt;
  end

  assign in_stall        = (state_r != S_IDLE);
  assign out_valid       = out_valid_r;
  assign out_status      = out_status_r;
  assign out_symbol      = out_symbol_r;
  assign out_frequency   = out_freq_r;
  assign out_entry_count = out_count_r;

  // list never grows past its capacity
  a_len_bound: assert property (@(posedge clk) disable iff (!rst_n)
    len_r <= LEN_FULL)
    else $error("entry count beyond capacity");

  // a result only appears out of the result state
  a_out_src: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !$past(out_valid_r)) |-> $past(state_r == S_RESULT))
    else $error("result loaded outside result state");

  // the swap partner is never ahead of the hit entry
  a_scan_order: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SCAN || state_r == S_SWAP_A) |-> (jdx_r >= hit_r))
    else $error("swap partner ahead of hit entry");

  // a request is only taken with no walk in flight
  a_take_idle: assert property (@(posedge clk) disable iff (!rst_n)
    in_take |=> !$past(pend_r))
    else $error("request taken during a walk");

endmodule

/* tb/sv/sfl_result_checker.sv */
`timescale 1ns / 100ps
// result checker for the frequency-sorted symbol list: watches both channels, predicts, compares
module sfl_result_checker (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  input  logic        in_stall,
  input  logic [1:0]  in_operation,
  input  logic [7:0]  in_symbol,
  input  logic [7:0]  in_position,
  input  logic        out_valid,
  input  logic        out_stall,
  input  logic [1:0]  out_status,
  input  logic [7:0]  out_symbol,
  input  logic [31:0] out_frequency,
  input  logic [8:0]  out_entry_count,
  output int          fail_count,
  output int          waiting,
  output int          checked_count
);
  import sfl_pkg::*;

  localparam int          MAX_ENTRIES = 256;
  localparam logic [31:0] COUNT_MAX   = '1;

  typedef struct packed {
    status_t     status;
    logic [7:0]  symbol;
    logic [31:0] frequency;
    logic [8:0]  entry_count;
  } list_reply_t;

  logic [7:0]  sym_at [MAX_ENTRIES];
  logic [31:0] cnt_at [MAX_ENTRIES];
  int          held = 0;
  int          errors = 0;
  int          checked = 0;
  list_reply_t replies [$];

  // trade places with the last entry of the following run of lower counts
  function automatic void move_past_lower(int at);
    int          j;
    logic [7:0]  s;
    logic [31:0] c;
    j = at;
    while (j + 1 < held && cnt_at[at] > cnt_at[j + 1]) j++;
    if (j != at) begin
      s = sym_at[at];
      c = cnt_at[at];
      sym_at[at] = sym_at[j];
      cnt_at[at] = cnt_at[j];
      sym_at[j] = s;
      cnt_at[j] = c;
    end
  endfunction

  function automatic list_reply_t apply_request(logic [1:0] op, logic [7:0] sym,
                                                logic [7:0] pos);
    list_reply_t r;
    int          i;
    int          hit;
    r.status = STAT_REFUSED;
    r.symbol = 8'd0;
    r.frequency = 32'd0;
    hit = -1;
    case (op) inside
      OP_COUNT: begin
        for (i = 0; i < held; i++) begin
          if (hit < 0 && sym_at[i] == sym) hit = i;
        end
        if (hit >= 0) begin
          if (cnt_at[hit] != COUNT_MAX) cnt_at[hit] = cnt_at[hit] + 32'd1;
          r.status = STAT_COUNTED;
          r.symbol = sym;
          r.frequency = cnt_at[hit];
          move_past_lower(hit);
        end else if (held >= MAX_ENTRIES) begin
          r.symbol = sym;
        end else begin
          for (i = held; i > 0; i--) begin
            sym_at[i] = sym_at[i - 1];
            cnt_at[i] = cnt_at[i - 1];
          end
          sym_at[0] = sym;
          cnt_at[0] = 32'd1;
          held++;
          move_past_lower(0);
          r.status = STAT_ADDED;
          r.symbol = sym;
          r.frequency = 32'd1;
        end
      end
      OP_READ, OP_REMOVE: begin
        if (pos < held) begin
          r.status = STAT_DONE;
          r.symbol = sym_at[pos];
          r.frequency = cnt_at[pos];
          if (op == OP_REMOVE) begin
            for (i = pos; i + 1 < held; i++) begin
              sym_at[i] = sym_at[i + 1];
              cnt_at[i] = cnt_at[i + 1];
            end
            held--;
          end
        end
      end
      default: ;
    endcase
    r.entry_count = 9'(held);
    return r;
  endfunction

  always @(posedge clk) begin : watch
    list_reply_t want;
    if (!rst_n) begin
      held = 0;
      replies.delete();
    end else begin
      if (in_valid && !in_stall)
        replies.push_back(apply_request(in_operation, in_symbol, in_position));
      if (out_valid && !out_stall) begin
        checked++;
        if (replies.size() == 0) begin
          $error("result with no request pending: status %0d symbol %0d", out_status,
                 out_symbol);
          errors++;
        end else begin
          want = replies.pop_front();
          if (out_status !== want.status) begin
            $error("out_status: expected %0d, got %0d", want.status, out_status);
            errors++;
          end
          if (out_symbol !== want.symbol) begin
            $error("out_symbol: expected %0d, got %0d", want.symbol, out_symbol);
            errors++;
          end
          if (out_frequency !== want.frequency) begin
            $error("out_frequency: expected %0d, got %0d", want.frequency, out_frequency);
            errors++;
          end
          if (out_entry_count !== want.entry_count) begin
            $error("out_entry_count: expected %0d, got %0d", want.entry_count,
                   out_entry_count);
            errors++;
          end
        end
      end
    end
    fail_count <= errors;
    waiting <= replies.size();
    checked_count <= checked;
  end

endmodule

/* tb/sv/tb_sorted_symbol_frequency_list_core.sv */
`timescale 1ns / 100ps
// testbench top for the frequency-sorted symbol list core: stimulus, back-pressure and verdict
module tb_sorted_symbol_frequency_list_core;
  import sfl_pkg::*;

  localparam logic [1:0] OP_UNDEFINED    = 2'd3;
  localparam int         CYCLE_LIMIT     = 4_000_000;
  localparam int         SETTLE_CYCLES   = 600;
  localparam int         MAX_GAP         = 13;
  localparam int         PRESSURE_AT     = 60;
  localparam int         PRESSURE_CYCLES = 400;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [1:0]  in_operation = OP_COUNT;
  logic [7:0]  in_symbol = 8'd0;
  logic [7:0]  in_position = 8'd0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [1:0]  out_status;
  logic [7:0]  out_symbol;
  logic [31:0] out_frequency;
  logic [8:0]  out_entry_count;

  int fail_count;
  int waiting;
  int checked_count;

  logic [8:0] list_hint = '0;
  logic [8:0] peak_len = '0;
  bit         tx_steady = 1'b0;
  bit         rx_steady = 1'b0;
  int         sent_total = 0;
  int         sent_per_op [4] = '{0, 0, 0, 0};

  sorted_symbol_frequency_list_core DUT (.*);

  sfl_result_checker u_result_checker (.*);

  always #5 clk = ~clk;

  // list length as last reported, used to aim ranks
  always @(posedge clk) begin
    if (!rst_n) begin
      list_hint <= '0;
    end else if (out_valid && !out_stall) begin
      list_hint <= out_entry_count;
      if (out_entry_count > peak_len) peak_len <= out_entry_count;
    end
  end

  function automatic logic [7:0] pick_rank();
    if (list_hint == 0 || $urandom_range(0, 7) == 0) return 8'($urandom_range(0, 255));
    return 8'($urandom_range(0, int'(list_hint) - 1));
  endfunction

  task automatic send_request(input logic [1:0] op, input logic [7:0] sym,
                              input logic [7:0] pos);
    int gap;
    if (sent_total % 50 == 0) tx_steady = ($urandom_range(0, 3) == 0);
    gap = tx_steady ? 0 : $urandom_range(0, MAX_GAP);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_operation <= op;
    in_symbol <= sym;
    in_position <= pos;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sent_total++;
    sent_per_op[op]++;
  endtask

  initial begin : receiver
    int  hold;
    int  taken;
    bit  pressed;
    taken = 0;
    pressed = 1'b0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      if (!pressed && taken == PRESSURE_AT) begin
        pressed = 1'b1;
        out_stall <= 1'b1;
        repeat (PRESSURE_CYCLES) @(posedge clk);
      end
      hold = rx_steady ? 0 : $urandom_range(0, MAX_GAP);
      if (hold > 0) begin
        out_stall <= 1'b1;
        repeat (hold) @(posedge clk);
      end
      out_stall <= 1'b0;
      @(posedge clk);
      while (!out_valid) @(posedge clk);
      taken++;
      if (taken % 47 == 0) rx_steady = ($urandom_range(0, 2) == 0);
    end
  end

  initial begin : watchdog
    int cycles;
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("DONE: errors detected");
    $finish;
  end

  initial begin : stimulus
    logic [7:0] pool [12];
    logic [7:0] order [256];
    logic [7:0] tmp;
    int         k;
    int         j;
    int         roll;

    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // empty list, refusals, front inserts, swaps, edges of the rank range
    send_request(OP_READ, 8'h00, 8'd0);
    send_request(OP_REMOVE, 8'hFF, 8'hFF);
    send_request(OP_UNDEFINED, 8'hFF, 8'hFF);
    send_request(OP_COUNT, 8'h00, 8'd0);
    send_request(OP_COUNT, 8'hFF, 8'd0);
    send_request(OP_COUNT, 8'hFF, 8'hFF);
    send_request(OP_COUNT, 8'hFF, 8'd0);
    send_request(OP_COUNT, 8'h00, 8'd0);
    send_request(OP_COUNT, 8'h5A, 8'd0);
    send_request(OP_COUNT, 8'hA5, 8'd0);
    send_request(OP_COUNT, 8'h5A, 8'd0);
    send_request(OP_READ, 8'h00, 8'd0);
    send_request(OP_READ, 8'h00, 8'd1);
    send_request(OP_READ, 8'h00, 8'd3);
    send_request(OP_READ, 8'h00, 8'd4);
    send_request(OP_REMOVE, 8'h00, 8'd1);
    send_request(OP_REMOVE, 8'h00, 8'd3);
    send_request(OP_REMOVE, 8'h00, 8'd2);
    send_request(OP_COUNT, 8'h80, 8'd0);
    send_request(OP_REMOVE, 8'h00, 8'd0);
    send_request(OP_READ, 8'h00, 8'hFF);
    send_request(OP_COUNT, 8'h01, 8'd0);
    send_request(OP_UNDEFINED, 8'h00, 8'h00);

    // small alphabet so counts climb and reorder
    for (k = 0; k < 12; k++) pool[k] = 8'($urandom_range(0, 255));
    for (k = 0; k < 700; k++) begin
      roll = $urandom_range(0, 99);
      if (roll < 66)
        send_request(OP_COUNT, pool[$urandom_range(0, 11)], 8'($urandom_range(0, 255)));
      else if (roll < 70)
        send_request(OP_COUNT, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
      else if (roll < 85)
        send_request(OP_READ, 8'($urandom_range(0, 255)), pick_rank());
      else if (roll < 95)
        send_request(OP_REMOVE, 8'($urandom_range(0, 255)), pick_rank());
      else
        send_request(OP_UNDEFINED, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
    end

    // every symbol once, in shuffled order, fills the list
    for (k = 0; k < 256; k++) order[k] = 8'(k);
    for (k = 255; k > 0; k--) begin
      j = $urandom_range(0, k);
      tmp = order[k];
      order[k] = order[j];
      order[j] = tmp;
    end
    for (k = 0; k < 256; k++) send_request(OP_COUNT, order[k], 8'($urandom_range(0, 255)));
    send_request(OP_READ, 8'h00, 8'hFF);
    send_request(OP_REMOVE, 8'h00, 8'hFF);

    for (k = 0; k < 120; k++) begin
      roll = $urandom_range(0, 99);
      if (roll < 40)
        send_request(OP_COUNT, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
      else if (roll < 70)
        send_request(OP_READ, 8'($urandom_range(0, 255)), pick_rank());
      else if (roll < 85)
        send_request(OP_REMOVE, 8'($urandom_range(0, 255)), pick_rank());
      else
        send_request(OP_READ, 8'($urandom_range(0, 255)), 8'hFF);
    end

    // drain
    for (k = 0; k < 260; k++)
      send_request(OP_REMOVE, 8'($urandom_range(0, 255)), pick_rank());

    // open mix over the whole field ranges
    for (k = 0; k < 220; k++) begin
      roll = $urandom_range(0, 99);
      if (roll < 55)
        send_request(OP_COUNT, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
      else if (roll < 75)
        send_request(OP_READ, 8'($urandom_range(0, 255)), pick_rank());
      else if (roll < 95)
        send_request(OP_REMOVE, 8'($urandom_range(0, 255)), pick_rank());
      else
        send_request(OP_UNDEFINED, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
    end

    in_valid <= 1'b0;
    @(posedge clk);
    while (waiting != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);

    $display("requests: %0d count, %0d read, %0d remove, %0d undefined; %0d results compared",
             sent_per_op[OP_COUNT], sent_per_op[OP_READ], sent_per_op[OP_REMOVE],
             sent_per_op[OP_UNDEFINED], checked_count);
    $display("list reached %0d entries, drained, and rode out a %0d-cycle output hold-off",
             peak_len, PRESSURE_CYCLES);
    if (fail_count == 0 && waiting == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

/* files.f */
rtl/sfl_pkg.sv
rtl/sorted_symbol_frequency_list_core.sv
tb/sv/sfl_result_checker.sv
tb/sv/tb_sorted_symbol_frequency_list_core.sv
